// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file fbcc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every aclk edge outside of reset.
`define FBCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every aclk edge, reset cycles included.
`define FBCC_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/core/fbcc_pkg.sv =====
`timescale 1ns / 1ps

package fbcc_pkg;

    localparam int CHANNEL_LIMIT = 8;
    localparam int CH_W         = (CHANNEL_LIMIT > 1) ? $clog2(CHANNEL_LIMIT) : 1;
    localparam int CNT_W        = 4;
    localparam int ID_W         = 8;
    localparam int SEQ_W        = 32;
    localparam int LINE_W       = 16;
    localparam int NEXT_W       = 17;
    localparam int CTR_W        = 32;
    localparam int HEIGHT_W     = 16;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;

    localparam int S_DATA_W     = 88;
    localparam int M_DATA_W     = 200;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    localparam logic [1:0] VERDICT_NONE       = 2'd0;
    localparam logic [1:0] VERDICT_COMPLETE   = 2'd1;
    localparam logic [1:0] VERDICT_INCOMPLETE = 2'd2;

    typedef enum logic [1:0] {
        KIND_BLOCK,
        KIND_TICK,
        KIND_DISCARD,
        KIND_HEIGHT
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [CH_W-1:0]    ch;
        logic [SEQ_W-1:0]   seq;
        logic [LINE_W-1:0]  pos;
        logic [LINE_W-1:0]  lines;
    } item_t;

endpackage

// ===== rtl/core/fbcc_queue.sv =====
`timescale 1ns / 1ps

module fbcc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fbcc_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output fbcc_pkg::item_t head_item
);

    fbcc_pkg::item_t                   entry_reg [fbcc_pkg::QUEUE_DEPTH];
    logic [fbcc_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [fbcc_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [fbcc_pkg::QCNT_W-1:0]       count_reg;
    logic [fbcc_pkg::QCNT_W-1:0]       count_next;
    logic                              do_push;
    logic                              do_pop;

    assign full      = (count_reg == fbcc_pkg::QCNT_W'(fbcc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/fbcc_front.sv =====
`timescale 1ns / 1ps

module fbcc_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fbcc_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                               s_tuser,
    input  logic [fbcc_pkg::CNT_W-1:0]         channel_count,
    input  logic [fbcc_pkg::HEIGHT_W-1:0]      frame_height,
    input  logic                               q_full,
    output logic                               q_push,
    output fbcc_pkg::item_t                    q_item
);

    logic [fbcc_pkg::ID_W-1:0]     channel_id;
    logic [fbcc_pkg::SEQ_W-1:0]    frame_seq;
    logic [fbcc_pkg::LINE_W-1:0]   start_line;
    logic [fbcc_pkg::LINE_W-1:0]   block_lines;
    logic [fbcc_pkg::HEIGHT_W-1:0] block_frame_height;
    logic                          out_of_range;

    assign channel_id         = s_tdata[7:0];
    assign frame_seq          = s_tdata[39:8];
    assign start_line         = s_tdata[55:40];
    assign block_lines        = s_tdata[71:56];
    assign block_frame_height = s_tdata[87:72];

    // Channel count never exceeds the channel limit, so one compare covers both bounds.
    assign out_of_range = (channel_count == '0) ||
                          ({1'b0, channel_id} >= (fbcc_pkg::ID_W + 1)'(channel_count));

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.ch    = channel_id[fbcc_pkg::CH_W-1:0];
        q_item.seq   = frame_seq;
        q_item.pos   = start_line;
        q_item.lines = block_lines;
        if (s_tuser) begin
            q_item.kind = fbcc_pkg::KIND_TICK;
        end else if (out_of_range) begin
            q_item.kind = fbcc_pkg::KIND_DISCARD;
        end else if (block_frame_height != frame_height) begin
            q_item.kind = fbcc_pkg::KIND_HEIGHT;
        end else begin
            q_item.kind = fbcc_pkg::KIND_BLOCK;
        end
    end

endmodule

// ===== rtl/core/fbcc_back.sv =====
`timescale 1ns / 1ps

module fbcc_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               state_clear,
    input  logic [fbcc_pkg::HEIGHT_W-1:0]      frame_height,
    input  logic                               q_valid,
    input  fbcc_pkg::item_t                    q_item,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fbcc_pkg::M_DATA_W-1:0]      m_tdata
);

    logic [fbcc_pkg::CHANNEL_LIMIT-1:0] locked_reg;
    logic [fbcc_pkg::SEQ_W-1:0]     cur_seq_reg   [fbcc_pkg::CHANNEL_LIMIT];
    logic [fbcc_pkg::NEXT_W-1:0]    next_line_reg [fbcc_pkg::CHANNEL_LIMIT];

    logic [fbcc_pkg::CTR_W-1:0] recv_reg,     recv_next;
    logic [fbcc_pkg::CTR_W-1:0] last_tick_reg, last_tick_next;
    logic [fbcc_pkg::CTR_W-1:0] complete_reg, complete_next;
    logic [fbcc_pkg::CTR_W-1:0] incomplete_reg, incomplete_next;
    logic [fbcc_pkg::CTR_W-1:0] seq_err_reg,  seq_err_next;
    logic [fbcc_pkg::CTR_W-1:0] line_err_reg, line_err_next;

    logic                           m_valid_reg;
    logic [fbcc_pkg::M_DATA_W-1:0]  m_data_reg;
    logic [fbcc_pkg::M_DATA_W-1:0]  m_data_next;

    logic                           cur_locked;
    logic [fbcc_pkg::SEQ_W-1:0]     cur_seq;
    logic [fbcc_pkg::NEXT_W-1:0]    cur_next_line;

    logic                           lock_wr, lock_val;
    logic                           seq_wr;
    logic                           line_wr;
    logic [fbcc_pkg::NEXT_W-1:0]    line_val;

    logic                           discarded;
    logic [1:0]                     verdict;
    logic                           seq_seen, line_seen;
    logic [fbcc_pkg::CTR_W-1:0]     delta;
    logic [fbcc_pkg::CTR_W-1:0]     seq_out, line_out;

    assign q_pop    = q_valid && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign cur_locked    = locked_reg[q_item.ch];
    assign cur_seq       = cur_seq_reg[q_item.ch];
    assign cur_next_line = next_line_reg[q_item.ch];

    always_comb begin
        recv_next       = recv_reg;
        last_tick_next  = last_tick_reg;
        complete_next   = complete_reg;
        incomplete_next = incomplete_reg;
        seq_err_next    = seq_err_reg;
        line_err_next   = line_err_reg;
        lock_wr   = 1'b0;
        lock_val  = 1'b0;
        seq_wr    = 1'b0;
        line_wr   = 1'b0;
        line_val  = {1'b0, q_item.lines};
        discarded = 1'b0;
        verdict   = fbcc_pkg::VERDICT_NONE;
        seq_seen  = 1'b0;
        line_seen = 1'b0;
        delta     = '0;
        case (q_item.kind)
            fbcc_pkg::KIND_TICK: begin
                delta          = recv_reg - last_tick_reg;
                last_tick_next = recv_reg;
                seq_err_next   = '0;
                line_err_next  = '0;
            end
            fbcc_pkg::KIND_DISCARD: begin
                recv_next = recv_reg + 1'b1;
                discarded = 1'b1;
            end
            fbcc_pkg::KIND_HEIGHT: begin
                recv_next    = recv_reg + 1'b1;
                seq_err_next = seq_err_reg + 1'b1;
                seq_seen     = 1'b1;
                lock_wr      = 1'b1;
                lock_val     = 1'b0;
            end
            fbcc_pkg::KIND_BLOCK: begin
                recv_next = recv_reg + 1'b1;
                if (!cur_locked) begin
                    // Acquire lock only on a frame start.
                    if (q_item.pos == '0) begin
                        lock_wr  = 1'b1;
                        lock_val = 1'b1;
                        seq_wr   = 1'b1;
                        line_wr  = 1'b1;
                    end
                end else if (q_item.pos == '0) begin
                    // Close the running frame.
                    if (cur_next_line == {1'b0, frame_height}) begin
                        complete_next = complete_reg + 1'b1;
                        verdict       = fbcc_pkg::VERDICT_COMPLETE;
                    end else begin
                        incomplete_next = incomplete_reg + 1'b1;
                        verdict         = fbcc_pkg::VERDICT_INCOMPLETE;
                    end
                    if (q_item.seq != cur_seq + 1'b1) begin
                        seq_err_next = seq_err_reg + 1'b1;
                        seq_seen     = 1'b1;
                    end
                    seq_wr  = 1'b1;
                    line_wr = 1'b1;
                end else begin
                    if (q_item.seq != cur_seq) begin
                        seq_err_next = seq_err_reg + 1'b1;
                        seq_seen     = 1'b1;
                        seq_wr       = 1'b1;
                    end
                    if ({1'b0, q_item.pos} != cur_next_line) begin
                        line_err_next = line_err_reg + 1'b1;
                        line_seen     = 1'b1;
                    end
                    line_wr  = 1'b1;
                    line_val = {1'b0, q_item.pos} + {1'b0, q_item.lines};
                end
            end
            default: begin
                recv_next = recv_reg;
            end
        endcase

        // Tick reports the counts before clearing; blocks report them after update.
        if (q_item.kind == fbcc_pkg::KIND_TICK) begin
            seq_out  = seq_err_reg;
            line_out = line_err_reg;
        end else begin
            seq_out  = seq_err_next;
            line_out = line_err_next;
        end

        m_data_next = {3'b000, line_out, seq_out, incomplete_next, complete_next,
                       delta, recv_next, line_seen, seq_seen, verdict, discarded};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || state_clear) begin
            locked_reg     <= '0;
            recv_reg       <= '0;
            last_tick_reg  <= '0;
            complete_reg   <= '0;
            incomplete_reg <= '0;
            seq_err_reg    <= '0;
            line_err_reg   <= '0;
        end else if (q_pop) begin
            recv_reg       <= recv_next;
            last_tick_reg  <= last_tick_next;
            complete_reg   <= complete_next;
            incomplete_reg <= incomplete_next;
            seq_err_reg    <= seq_err_next;
            line_err_reg   <= line_err_next;
            if (lock_wr) begin
                locked_reg[q_item.ch] <= lock_val;
            end
        end
    end

    // Sequence and line entries are only read under lock, so they need no reset.
    always_ff @(posedge aclk) begin
        if (q_pop && seq_wr) begin
            cur_seq_reg[q_item.ch] <= q_item.seq;
        end
        if (q_pop && line_wr) begin
            next_line_reg[q_item.ch] <= line_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ===== rtl/core/frame_block_continuity_checker.sv =====
`timescale 1ns / 1ps

// Frame block continuity checker: takes one word per clock on the s_ side,
// while the queue has room, and returns exactly one result word per input
// word on the m_ side, in order. A word is classified on entry (report tick,
// discarded block, height mismatch or regular block), parked in a two-entry
// queue, and then executed by the back stage, whose single per-channel
// read-modify-write and counter update settles the rate at one word per cycle
// while the output is not stalled. An accepted word passes the queue entry and
// then the back stage's output register before m_tvalid rises. A stalled
// output holds its word while the queue keeps taking input until it fills.
// Configuration writes land immediately and clear the channel locks and
// counters in the same cycle; issue them only while no word is in flight.
// A channel_count whose low four bits exceed the channel limit is ignored.
module frame_block_continuity_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [fbcc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fbcc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Input words
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata from bit 0: channel_id[8], frame_seq[32], start_line[16],
    //                   block_lines[16], block_frame_height[16]
    input  logic [fbcc_pkg::S_DATA_W-1:0]        s_tdata,
    // tuser: func (0 image block, 1 report tick)
    input  logic                                 s_tuser,
    // Result words
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata from bit 0: discarded[1], frame_verdict[2], seq_error_seen[1],
    //                   line_error_seen[1], received_total[32], received_delta[32],
    //                   complete_total[32], incomplete_total[32],
    //                   seq_error_count[32], line_error_count[32], zero pad[3]
    output logic [fbcc_pkg::M_DATA_W-1:0]        m_tdata
);

    logic [fbcc_pkg::CNT_W-1:0]    channel_count_reg;
    logic [fbcc_pkg::HEIGHT_W-1:0] frame_height_reg;
    logic                          cnt_write, height_write, state_clear;

    logic                          q_full, q_push, q_pop, q_valid;
    fbcc_pkg::item_t               push_item, head_item;

    // Accept a channel count only within the channel limit.
    assign cnt_write = cfg_wr_en && (cfg_index == fbcc_pkg::REG_CHANNEL_COUNT) &&
                       (cfg_wdata[fbcc_pkg::CNT_W-1:0] <=
                        fbcc_pkg::CNT_W'(fbcc_pkg::CHANNEL_LIMIT));
    assign height_write = cfg_wr_en && (cfg_index == fbcc_pkg::REG_FRAME_HEIGHT);
    assign state_clear  = cnt_write || height_write;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= '0;
            frame_height_reg  <= '0;
        end else begin
            if (cnt_write) begin
                channel_count_reg <= cfg_wdata[fbcc_pkg::CNT_W-1:0];
            end
            if (height_write) begin
                frame_height_reg <= cfg_wdata[fbcc_pkg::HEIGHT_W-1:0];
            end
        end
    end

    // Front: accept and classify.
    fbcc_front u_front (
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .channel_count     (channel_count_reg),
        .frame_height      (frame_height_reg),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_item            (push_item)
    );

    // Decouple the two sides so each can stall on its own.
    fbcc_queue u_queue (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .push              (q_push),
        .push_item         (push_item),
        .full              (q_full),
        .pop               (q_pop),
        .not_empty         (q_valid),
        .head_item         (head_item)
    );

    // Back: update channel state and counters, register the result.
    fbcc_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .state_clear       (state_clear),
        .frame_height      (frame_height_reg),
        .q_valid           (q_valid),
        .q_item            (head_item),
        .q_pop             (q_pop),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata)
    );

endmodule

// ===== rtl/core/fbcc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbcc_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [fbcc_pkg::M_DATA_W-1:0]      m_tdata
);

    `FBCC_ASSERT_ANY(a_idle_after_reset, !aresetn |=> !m_tvalid && s_tready,
                     "block not idle right after reset")
    `FBCC_ASSERT(a_hold_when_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
                 "stalled result changed")
    `FBCC_ASSERT(a_verdict_code, m_tvalid |-> m_tdata[2:1] != 2'd3,
                 "invalid frame verdict code")
    `FBCC_ASSERT(a_discard_clean, m_tvalid && m_tdata[0] |-> m_tdata[4:1] == 4'd0,
                 "discarded word carries verdict or error flags")
    `FBCC_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[199:197] == 3'd0,
                 "result pad bits not zero")

endmodule

bind frame_block_continuity_checker fbcc_checker u_fbcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Input word kinds carried on s_tuser
    localparam logic FUNC_BLOCK = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Register indexes past the end of the map: writes there must do nothing
    localparam logic [fbcc_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [fbcc_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int DRAIN_CYCLES = 8;       // idle margin after the block has drained
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int CYCLE_LIMIT  = 500000;

    // s_tdata layout, lowest bits first: channel_id, frame_seq, start_line,
    // block_lines, block_frame_height
    typedef struct packed {
        logic [15:0] block_frame_height;
        logic [15:0] block_lines;
        logic [15:0] start_line;
        logic [31:0] frame_seq;
        logic [7:0]  channel_id;
    } block_word_t;

    typedef struct packed {
        logic        func;
        block_word_t data;
    } stim_word_t;

    // m_tdata layout, lowest bits first: discarded, frame_verdict,
    // seq_error_seen, line_error_seen, then the six 32-bit counters, zero pad
    typedef struct packed {
        logic [2:0]  pad;
        logic [31:0] line_error_count;
        logic [31:0] seq_error_count;
        logic [31:0] incomplete_total;
        logic [31:0] complete_total;
        logic [31:0] received_delta;
        logic [31:0] received_total;
        logic        line_error_seen;
        logic        seq_error_seen;
        logic [1:0]  frame_verdict;
        logic        discarded;
    } result_word_t;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [fbcc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fbcc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [fbcc_pkg::S_DATA_W-1:0]   s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [fbcc_pkg::M_DATA_W-1:0]   m_tdata;

    frame_block_continuity_checker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Words waiting to be sent, and results predicted for accepted words
    stim_word_t   queued_words[$];
    result_word_t awaited_results[$];

    int fail_count    = 0;
    int hold_requests = 0;     // bumped by the sequence to ask for a hold-off
    int cycle_count   = 0;

    // ------------------------------------------------------------------
    // Predictor state: configuration, per-channel tracking and counters
    // ------------------------------------------------------------------
    logic [3:0]  chan_count;
    logic [15:0] height_cfg;
    logic        ch_locked [fbcc_pkg::CHANNEL_LIMIT];
    logic [31:0] ch_seq    [fbcc_pkg::CHANNEL_LIMIT];
    logic [16:0] ch_next   [fbcc_pkg::CHANNEL_LIMIT];
    logic [31:0] blocks_rx, blocks_at_tick, frames_done, frames_short;
    logic [31:0] seq_err_cnt, line_err_cnt;

    function automatic void clear_tracking();
        for (int i = 0; i < fbcc_pkg::CHANNEL_LIMIT; i++) begin
            ch_locked[i] = 1'b0;
            ch_seq[i]    = '0;
            ch_next[i]   = '0;
        end
        blocks_rx      = '0;
        blocks_at_tick = '0;
        frames_done    = '0;
        frames_short   = '0;
        seq_err_cnt    = '0;
        line_err_cnt   = '0;
    endfunction

    // Accepted writes store the register and wipe all tracking; an oversized
    // channel count and unmapped indexes change nothing at all.
    function automatic void apply_config(logic [fbcc_pkg::CFG_IDX_W-1:0] idx,
                                         logic [fbcc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            fbcc_pkg::REG_CHANNEL_COUNT: begin
                if (data[3:0] <= fbcc_pkg::CHANNEL_LIMIT) begin
                    chan_count = data[3:0];
                    clear_tracking();
                end
            end
            fbcc_pkg::REG_FRAME_HEIGHT: begin
                height_cfg = data;
                clear_tracking();
            end
            default: ;
        endcase
    endfunction

    // Advance the continuity tracking by one word and return the result word
    function automatic result_word_t continuity_result(stim_word_t w);
        result_word_t r;
        logic [7:0]   ch;
        logic [2:0]   slot;
        r    = '0;
        ch   = w.data.channel_id;
        slot = ch[2:0];
        if (w.func == FUNC_TICK) begin
            // Report: delta since last tick, error counts before clearing
            r.received_delta  = blocks_rx - blocks_at_tick;
            blocks_at_tick    = blocks_rx;
            r.seq_error_count = seq_err_cnt;
            r.line_error_count = line_err_cnt;
            seq_err_cnt       = '0;
            line_err_cnt      = '0;
        end else begin
            blocks_rx++;
            if (chan_count == 0 || ch >= chan_count || ch >= fbcc_pkg::CHANNEL_LIMIT) begin
                r.discarded = 1'b1;
            end else if (w.data.block_frame_height != height_cfg) begin
                // Height mismatch: sequence error, lose lock, nothing else
                seq_err_cnt++;
                r.seq_error_seen = 1'b1;
                ch_locked[slot]  = 1'b0;
            end else if (!ch_locked[slot]) begin
                // Acquire lock only on a block that opens a frame
                if (w.data.start_line == 0) begin
                    ch_locked[slot] = 1'b1;
                    ch_seq[slot]    = w.data.frame_seq;
                    ch_next[slot]   = {1'b0, w.data.block_lines};
                end
            end else if (w.data.start_line == 0) begin
                // New frame closes the previous one
                if (ch_next[slot] == {1'b0, height_cfg}) begin
                    frames_done++;
                    r.frame_verdict = fbcc_pkg::VERDICT_COMPLETE;
                end else begin
                    frames_short++;
                    r.frame_verdict = fbcc_pkg::VERDICT_INCOMPLETE;
                end
                if (w.data.frame_seq != ch_seq[slot] + 32'd1) begin
                    seq_err_cnt++;
                    r.seq_error_seen = 1'b1;
                end
                ch_seq[slot]  = w.data.frame_seq;
                ch_next[slot] = {1'b0, w.data.block_lines};
            end else begin
                if (w.data.frame_seq != ch_seq[slot]) begin
                    seq_err_cnt++;
                    r.seq_error_seen = 1'b1;
                    ch_seq[slot]     = w.data.frame_seq;
                end
                if ({1'b0, w.data.start_line} != ch_next[slot]) begin
                    line_err_cnt++;
                    r.line_error_seen = 1'b1;
                end
                ch_next[slot] = {1'b0, w.data.start_line} + {1'b0, w.data.block_lines};
            end
            r.seq_error_count  = seq_err_cnt;
            r.line_error_count = line_err_cnt;
        end
        r.received_total   = blocks_rx;
        r.complete_total   = frames_done;
        r.incomplete_total = frames_short;
        return r;
    endfunction

    // Wait draw shared by both sides; now and then open a stretch of zero waits
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued words, predict each one as it is accepted.
    // Configuration writes are mirrored here too, at the edge the block sees.
    // ------------------------------------------------------------------
    stim_word_t cur_word;
    int         send_gap  = 0;
    int         send_calm = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            send_gap   = 0;
            chan_count = '0;
            height_cfg = '0;
            clear_tracking();
        end else begin
            if (cfg_wr_en)
                apply_config(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(continuity_result(cur_word));
                send_gap = draw_wait(send_calm);
            end
            // Only touch the bus when the current word is gone or never was
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (queued_words.size() != 0) begin
                    cur_word = queued_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_word.func;
                    s_tdata  <= cur_word.data;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result word with the oldest prediction
    // ------------------------------------------------------------------
    int recv_gap    = 0;
    int recv_calm   = 0;
    int hold_left   = 0;
    int hold_served = 0;

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result_word(result_word_t want, result_word_t got);
        compare_field("discarded",        32'(want.discarded),       32'(got.discarded));
        compare_field("frame_verdict",    32'(want.frame_verdict),   32'(got.frame_verdict));
        compare_field("seq_error_seen",   32'(want.seq_error_seen),  32'(got.seq_error_seen));
        compare_field("line_error_seen",  32'(want.line_error_seen), 32'(got.line_error_seen));
        compare_field("received_total",   want.received_total,   got.received_total);
        compare_field("received_delta",   want.received_delta,   got.received_delta);
        compare_field("complete_total",   want.complete_total,   got.complete_total);
        compare_field("incomplete_total", want.incomplete_total, got.incomplete_total);
        compare_field("seq_error_count",  want.seq_error_count,  got.seq_error_count);
        compare_field("line_error_count", want.line_error_count, got.line_error_count);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word arrived with no prediction pending");
                    fail_count++;
                end else begin
                    check_result_word(awaited_results.pop_front(), m_tdata);
                end
                recv_gap = draw_wait(recv_calm);
            end
            // A fresh hold-off request starts a long stall, counted here
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [31:0] gen_seq [fbcc_pkg::CHANNEL_LIMIT];
    int          gen_pos [fbcc_pkg::CHANNEL_LIMIT];

    function automatic void restart_frames();
        for (int i = 0; i < fbcc_pkg::CHANNEL_LIMIT; i++) begin
            gen_seq[i] = $urandom;
            gen_pos[i] = 0;
        end
    endfunction

    task automatic push_block(logic [7:0] ch, logic [31:0] seq, logic [15:0] pos,
                              logic [15:0] lines, logic [15:0] bh);
        stim_word_t w;
        w.func = FUNC_BLOCK;
        w.data = '{block_frame_height: bh, block_lines: lines, start_line: pos,
                   frame_seq: seq, channel_id: ch};
        queued_words.push_back(w);
    endtask

    task automatic push_tick();
        stim_word_t w;
        w      = '0;
        w.func = FUNC_TICK;
        queued_words.push_back(w);
    endtask

    // Mostly well-formed frames split into blocks per channel; the rest is
    // ticks, pure noise, foreign channels and deliberately broken blocks.
    function automatic stim_word_t make_random_word(int nch, int h);
        stim_word_t w;
        int         ch;
        int         roll;
        int         pos;
        int         chunk;
        int         cap;
        w.func                    = FUNC_BLOCK;
        w.data.channel_id         = 8'($urandom);
        w.data.frame_seq          = $urandom;
        w.data.start_line         = 16'($urandom);
        w.data.block_lines        = 16'($urandom);
        w.data.block_frame_height = 16'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            w.func = FUNC_TICK;
            return w;
        end
        if (roll < 12 || nch == 0)
            return w;
        ch = (roll < 16) ? $urandom_range(nch, 255) : $urandom_range(0, nch - 1);
        w.data.channel_id         = 8'(ch);
        w.data.block_frame_height = 16'(h);
        if (roll < 16)
            return w;
        // Cut the frame short now and then
        if (roll >= 90 && roll < 93)
            gen_pos[ch] = 0;
        if (gen_pos[ch] == 0 || gen_pos[ch] >= h) begin
            gen_pos[ch] = 0;
            gen_seq[ch]++;
        end
        pos = gen_pos[ch];
        cap = (h + 3) / 4;
        if (cap < 1)
            cap = 1;
        if (h - pos <= 0)
            chunk = 0;
        else if ($urandom_range(0, 7) == 0)
            chunk = h - pos;
        else
            chunk = $urandom_range(1, (h - pos < cap) ? h - pos : cap);
        gen_pos[ch]               = pos + chunk;
        w.data.start_line         = 16'(pos);
        w.data.block_lines        = 16'(chunk);
        w.data.frame_seq          = gen_seq[ch];
        // Break the block in one way or another
        if (roll >= 93 && roll < 96)
            w.data.block_frame_height = 16'(h) ^ 16'($urandom_range(1, 65535));
        else if (roll >= 96 && roll < 98)
            w.data.start_line = 16'(pos) + 16'($urandom_range(1, 300));
        else if (roll >= 98)
            w.data.frame_seq = $urandom;
        return w;
    endfunction

    // Hold until the block has drained, then wait out the drain margin
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (queued_words.size() != 0 || s_tvalid || awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [fbcc_pkg::CFG_IDX_W-1:0] idx,
                             logic [fbcc_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Queue a run of random words; optionally stall the receiver at the start
    // or pause the sender halfway until all results are back.
    task automatic run_random(int n, int nch, int h, bit hold, bit pause);
        if (hold)
            hold_requests++;
        for (int i = 0; i < n; i++) begin
            if (pause && i == n / 2)
                wait_idle();
            queued_words.push_back(make_random_word(nch, h));
        end
    endtask

    task automatic run_setting(int nch, int h, int n, bit hold, bit pause);
        wait_idle();
        write_reg(fbcc_pkg::REG_CHANNEL_COUNT, 16'(nch));
        write_reg(fbcc_pkg::REG_FRAME_HEIGHT, 16'(h));
        @(negedge aclk);
        restart_frames();
        run_random(n, nch, h, hold, pause);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Out of reset no channel is configured: every block is dropped
        push_tick();
        push_block(8'd0, 32'd0, 16'd0, 16'd0, 16'd0);
        restart_frames();
        run_random(40, 0, 0, 1'b0, 1'b0);
        wait_idle();

        // Upper data bits are junk for the channel count and must be masked
        write_reg(fbcc_pkg::REG_CHANNEL_COUNT, 16'hFFF4);
        write_reg(fbcc_pkg::REG_FRAME_HEIGHT, 16'd8);
        @(negedge aclk);

        push_tick();
        push_block(8'd7, 32'd1, 16'd0, 16'd8, 16'd8);          // channel past count
        push_block(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_block(8'd0, 32'd5, 16'd3, 16'd2, 16'd8);          // unlocked, mid frame
        push_block(8'd0, 32'd5, 16'd0, 16'd4, 16'd9);          // height mismatch
        push_block(8'd0, 32'hFFFF_FFFF, 16'd0, 16'd4, 16'd8);  // lock
        push_block(8'd0, 32'hFFFF_FFFF, 16'd4, 16'd4, 16'd8);
        push_block(8'd0, 32'd0, 16'd0, 16'd3, 16'd8);          // complete, seq wraps
        push_block(8'd0, 32'd0, 16'd5, 16'd3, 16'd8);          // line gap
        push_block(8'd0, 32'd7, 16'd1, 16'd2, 16'd8);          // seq change and overlap
        push_tick();
        push_block(8'd0, 32'd9, 16'd0, 16'd8, 16'd8);          // incomplete, seq skip
        push_block(8'd1, 32'd100, 16'd0, 16'hFFFF, 16'd8);
        push_block(8'd1, 32'd100, 16'hFFFF, 16'hFFFF, 16'd8);  // next line past 16 bits
        push_block(8'd1, 32'd101, 16'd0, 16'd8, 16'd8);
        push_block(8'd3, 32'd0, 16'd0, 16'd8, 16'd8);          // last channel in range
        push_block(8'd3, 32'd0, 16'd0, 16'd8, 16'd0);          // mismatch drops lock
        push_block(8'd3, 32'd0, 16'd4, 16'd4, 16'd8);          // ignored while unlocked
        push_block(8'd3, 32'd1, 16'd0, 16'd8, 16'd8);          // relock, no verdict
        push_block(8'd0, 32'd10, 16'd0, 16'd8, 16'd8);         // clean close
        push_tick();
        push_tick();                                           // zero delta
        push_block(8'd4, 32'd1, 16'd0, 16'd8, 16'd8);          // channel equal to count
        wait_idle();

        // None of these may touch the register file or the tracking state
        write_reg(fbcc_pkg::REG_CHANNEL_COUNT, 16'h0009);
        write_reg(fbcc_pkg::REG_CHANNEL_COUNT, 16'h000F);
        write_reg(REG_SPARE_2, 16'h0001);
        write_reg(REG_SPARE_3, 16'hFFFF);
        @(negedge aclk);
        restart_frames();
        run_random(150, 4, 8, 1'b0, 1'b1);

        run_setting(8, 16,    260, 1'b1, 1'b0);
        run_setting(1, 1,     220, 1'b0, 1'b0);
        run_setting(8, 65535, 260, 1'b0, 1'b0);
        run_setting(5, 0,     200, 1'b0, 1'b0);
        run_setting(3, 100,   240, 1'b0, 1'b1);
        run_setting(8, 40,    260, 1'b1, 1'b0);
        run_setting(2, 7,     200, 1'b0, 1'b0);
        run_setting(0, 12,    40,  1'b0, 1'b0);

        wait_idle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
